FILE: rtl/joystick_axis_conditioner_macros.svh
// assertion macros shared by the joystick axis conditioner rtl
`ifndef JOYSTICK_AXIS_CONDITIONER_MACROS_SVH
`define JOYSTICK_AXIS_CONDITIONER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define JAC_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define JAC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/jac_pkg.sv
// shared constants and types of the joystick axis conditioner
`default_nettype none
package jac_pkg;

    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;
    localparam int SMOOTH_W = 17;
    localparam int CENTER_W = 12;
    localparam int STOP_W   = 13;
    localparam int BAND_W   = 12;

    localparam logic [SMOOTH_W-1:0] ONE_Q16 = 17'd65536;

    // register indexes (byte address = 4 * index)
    localparam logic [IDX_W-1:0] REG_SMOOTH = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER = 3'd1;
    localparam logic [IDX_W-1:0] REG_LOWER  = 3'd2;
    localparam logic [IDX_W-1:0] REG_UPPER  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BAND   = 3'd4;

    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 17'd6554;
    localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd2048;
    localparam logic [STOP_W-1:0]   LOWER_RESET  = 13'd68;
    localparam logic [STOP_W-1:0]   UPPER_RESET  = 13'd4098;
    localparam logic [BAND_W-1:0]   BAND_RESET   = 12'd30;

    typedef struct packed {
        logic [SMOOTH_W-1:0] smoothing_factor;
        logic [CENTER_W-1:0] center_point;
        logic [STOP_W-1:0]   lower_stop;
        logic [STOP_W-1:0]   upper_stop;
        logic [BAND_W-1:0]   dead_band;
    } cfg_t;

    // how the back end finishes a sample
    typedef enum logic [1:0] {
        KIND_BAND,
        KIND_CENTER,
        KIND_BELOW,
        KIND_ABOVE
    } kind_t;

endpackage
`default_nettype wire

FILE: rtl/jac_cfg.sv
// apb register bank of the joystick axis conditioner
`default_nettype none
module jac_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jac_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output jac_pkg::cfg_t               cfg
);

    jac_pkg::cfg_t                  cfg_reg;
    logic                           wr_en;
    logic [jac_pkg::IDX_W-1:0]      idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[jac_pkg::ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_factor <= jac_pkg::SMOOTH_RESET;
            cfg_reg.center_point     <= jac_pkg::CENTER_RESET;
            cfg_reg.lower_stop       <= jac_pkg::LOWER_RESET;
            cfg_reg.upper_stop       <= jac_pkg::UPPER_RESET;
            cfg_reg.dead_band        <= jac_pkg::BAND_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                jac_pkg::REG_SMOOTH: cfg_reg.smoothing_factor <= pwdata[16:0];
                jac_pkg::REG_CENTER: cfg_reg.center_point     <= pwdata[11:0];
                jac_pkg::REG_LOWER:  cfg_reg.lower_stop       <= pwdata[12:0];
                jac_pkg::REG_UPPER:  cfg_reg.upper_stop       <= pwdata[12:0];
                jac_pkg::REG_BAND:   cfg_reg.dead_band        <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            jac_pkg::REG_SMOOTH: prdata = {15'd0, cfg_reg.smoothing_factor};
            jac_pkg::REG_CENTER: prdata = {20'd0, cfg_reg.center_point};
            jac_pkg::REG_LOWER:  prdata = {19'd0, cfg_reg.lower_stop};
            jac_pkg::REG_UPPER:  prdata = {19'd0, cfg_reg.upper_stop};
            jac_pkg::REG_BAND:   prdata = {20'd0, cfg_reg.dead_band};
            default:             prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/jac_front.sv
// front end: sample intake, exponential filter and remap classification
`default_nettype none
module jac_front #(
    parameter int  SAMPLE_BITS = 12,
    parameter int  IN_W        = 16,
    parameter type cmd_t       = logic
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,
    input  jac_pkg::cfg_t       cfg,
    output cmd_t                cmd,
    output logic                push,
    input  logic                full
);

    localparam int DW     = (SAMPLE_BITS > jac_pkg::CENTER_W) ? SAMPLE_BITS : jac_pkg::CENTER_W;
    localparam int DEN_W  = DW + 1;
    localparam int NUM_W  = 2 * DW;
    localparam int PROD_W = SAMPLE_BITS + 19;
    localparam int ACC_W  = SAMPLE_BITS + 20;
    localparam logic [SAMPLE_BITS-1:0] FULL   = {SAMPLE_BITS{1'b1}};
    localparam logic [DW-1:0]          FULL_X = DW'(FULL);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ACC,
        F_CLASS,
        F_PUSH
    } state_t;

    state_t                         state_reg;
    logic [SAMPLE_BITS-1:0]         raw_reg;
    logic [SAMPLE_BITS-1:0]         filt_reg;
    logic [SAMPLE_BITS-1:0]         filt_next;
    logic                           primed_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [PROD_W-1:0]       prod_next;
    cmd_t                           cmd_reg;
    cmd_t                           cmd_next;

    logic [jac_pkg::SMOOTH_W-1:0]   a_sat;
    logic signed [SAMPLE_BITS:0]    diff;
    logic signed [ACC_W-1:0]        acc;

    logic [DW-1:0]                  s_x;
    logic [DW-1:0]                  c_x;
    logic [DW-1:0]                  distance;
    logic [DW-1:0]                  span;
    logic [DW-1:0]                  op_b;
    logic [DEN_W-1:0]               c_w;
    logic [DEN_W-1:0]               lo_w;
    logic [DEN_W-1:0]               hi_w;
    logic                           below;
    logic                           in_band;

    assign s_tready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_PUSH) && !full;
    assign cmd      = cmd_reg;

    // filter: f + a*(raw - f) / 2^16, one multiply then one add
    assign a_sat     = (cfg.smoothing_factor > jac_pkg::ONE_Q16) ? jac_pkg::ONE_Q16
                                                                 : cfg.smoothing_factor;
    assign diff      = $signed({1'b0, raw_reg}) - $signed({1'b0, filt_reg});
    assign prod_next = $signed({1'b0, a_sat}) * diff;
    assign acc       = $signed({4'd0, filt_reg, 16'd0}) + $signed({prod_reg[PROD_W-1], prod_reg});

    always_comb
    begin
        if (acc[ACC_W-1])
            filt_next = '0;
        else if (|acc[ACC_W-2:SAMPLE_BITS+16])
            filt_next = FULL;
        else
            filt_next = acc[SAMPLE_BITS+15:16];
    end

    // classification of the filtered sample against centre, band and stops
    assign s_x      = DW'(filt_reg);
    assign c_x      = DW'(cfg.center_point);
    assign c_w      = DEN_W'(cfg.center_point);
    assign lo_w     = DEN_W'(cfg.lower_stop);
    assign hi_w     = DEN_W'(cfg.upper_stop);
    assign below    = (s_x < c_x);
    assign distance = below ? (c_x - s_x) : (s_x - c_x);
    assign in_band  = (distance <= DW'(cfg.dead_band));
    assign span     = (c_x <= FULL_X) ? (FULL_X - c_x) : '0;
    assign op_b     = below ? c_x : span;

    always_comb
    begin
        cmd_next          = cmd_reg;
        cmd_next.smoothed = filt_reg;
        cmd_next.center   = c_x;
        cmd_next.num      = NUM_W'(distance) * NUM_W'(op_b);
        cmd_next.den      = below ? (c_w - lo_w) : (hi_w - c_w);
        if (in_band)
            cmd_next.kind = jac_pkg::KIND_BAND;
        else if (below)
            cmd_next.kind = (lo_w >= c_w) ? jac_pkg::KIND_CENTER : jac_pkg::KIND_BELOW;
        else
            cmd_next.kind = (hi_w <= c_w) ? jac_pkg::KIND_CENTER : jac_pkg::KIND_ABOVE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            filt_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        raw_reg   <= s_tdata[SAMPLE_BITS-1:0];
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:
                begin
                    if (!primed_reg)
                    begin
                        filt_reg   <= raw_reg;
                        primed_reg <= 1'b1;
                        state_reg  <= F_CLASS;
                    end
                    else
                    begin
                        prod_reg  <= prod_next;
                        state_reg <= F_ACC;
                    end
                end
                F_ACC:
                begin
                    filt_reg  <= filt_next;
                    state_reg <= F_CLASS;
                end
                F_CLASS:
                begin
                    cmd_reg   <= cmd_next;
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!full)
                        state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jac_queue.sv
// small fifo between the front and back ends
`default_nettype none
module jac_queue #(
    parameter type entry_t = logic,
    parameter int  DEPTH   = 2
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_data,
    input  logic    pop,
    output entry_t  pop_data,
    output logic    full,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/jac_back.sv
// back end: serial divider, final remap and output register
`default_nettype none
module jac_back #(
    parameter int  SAMPLE_BITS = 12,
    parameter int  OUT_W       = 24,
    parameter type cmd_t       = logic
) (
    input  logic                clk,
    input  logic                rst_n,
    output logic                pop,
    input  logic                empty,
    input  cmd_t                cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,
    output logic                m_tuser
);

    localparam int DW      = (SAMPLE_BITS > jac_pkg::CENTER_W) ? SAMPLE_BITS : jac_pkg::CENTER_W;
    localparam int DEN_W   = DW + 1;
    localparam int TRIAL_W = DEN_W + 1;
    localparam int NUM_W   = 2 * DW;
    localparam int CNT_W   = $clog2(DW);
    localparam logic [SAMPLE_BITS-1:0] FULL = {SAMPLE_BITS{1'b1}};

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } state_t;

    state_t                     state_reg;
    cmd_t                       cur_reg;
    logic [DEN_W-1:0]           rem_reg;
    logic [DEN_W-1:0]           rem_next;
    logic [DW-1:0]              quot_reg;
    logic [DW-1:0]              quot_next;
    logic                       ovf_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]     axis_reg;
    logic [SAMPLE_BITS-1:0]     axis_next;
    logic [SAMPLE_BITS-1:0]     smooth_reg;
    logic                       band_reg;

    logic [DW-1:0]              hi_part;
    logic                       ovf_in;
    logic                       needs_div;
    logic [TRIAL_W-1:0]         trial;
    logic [TRIAL_W-1:0]         trial_sub;
    logic                       ge;
    logic [DW:0]                sum;
    logic                       out_load;

    assign pop      = (state_reg == B_IDLE) && !empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({smooth_reg, axis_reg});
    assign m_tuser  = band_reg;

    // output register takes a new result when empty or being drained this cycle
    assign out_load = (state_reg == B_DONE) && (!m_tvalid_reg || m_tready);

    // quotient of 2^DW or more saturates either way, so only DW steps remain
    assign hi_part   = cmd.num[NUM_W-1:DW];
    assign ovf_in    = (DEN_W'(hi_part) >= cmd.den);
    assign needs_div = ((cmd.kind == jac_pkg::KIND_BELOW) || (cmd.kind == jac_pkg::KIND_ABOVE))
                       && !ovf_in;

    // one restoring step per cycle
    assign trial     = {rem_reg, quot_reg[DW-1]};
    assign ge        = (trial >= TRIAL_W'(cur_reg.den));
    assign trial_sub = trial - TRIAL_W'(cur_reg.den);
    assign rem_next  = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    assign quot_next = {quot_reg[DW-2:0], ge};

    assign sum = {1'b0, cur_reg.center} + {1'b0, quot_reg};

    always_comb
    begin
        case (cur_reg.kind)
            jac_pkg::KIND_BELOW:
            begin
                if (ovf_reg || (quot_reg >= cur_reg.center))
                    axis_next = '0;
                else
                    axis_next = SAMPLE_BITS'(cur_reg.center - quot_reg);
            end
            jac_pkg::KIND_ABOVE:
            begin
                if (ovf_reg || (sum > (DW + 1)'(FULL)))
                    axis_next = FULL;
                else
                    axis_next = sum[SAMPLE_BITS-1:0];
            end
            default: axis_next = cur_reg.center[SAMPLE_BITS-1:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        cur_reg   <= cmd;
                        ovf_reg   <= ovf_in;
                        rem_reg   <= DEN_W'(hi_part);
                        quot_reg  <= cmd.num[DW-1:0];
                        cnt_reg   <= CNT_W'(DW - 1);
                        state_reg <= needs_div ? B_DIV : B_DONE;
                    end
                end
                B_DIV:
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= quot_next;
                    if (cnt_reg == '0)
                        state_reg <= B_DONE;
                    else
                        cnt_reg <= cnt_reg - 1'b1;
                end
                B_DONE:
                begin
                    if (out_load)
                    begin
                        axis_reg   <= axis_next;
                        smooth_reg <= cur_reg.smoothed;
                        band_reg   <= (cur_reg.kind == jac_pkg::KIND_BAND);
                        state_reg  <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/joystick_axis_conditioner.sv
// top level of the joystick axis conditioner: one axis, filter then remap
// the divider runs only for results below or above the centre, not for centre, dead band
//   and saturated results; the first sample skips the filter update, which primes the filter
// the radix-2 divider in the back end limits the sample rate when it runs, the front end
//   otherwise; the front end takes no new sample until the last one is pushed to the queue
// reset: asynchronous, active low; state and configuration registers take their reset values, filter unprimed
`default_nettype none
`include "joystick_axis_conditioner_macros.svh"
module joystick_axis_conditioner #(
    parameter int SAMPLE_BITS = 12,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,     // raw_sample, zero padding
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_tdata,   // axis_value, smoothed_sample, padding
    output logic                            m_tuser,     // in_dead_band
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jac_pkg::ADDR_W-1:0]      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int DW    = (SAMPLE_BITS > jac_pkg::CENTER_W) ? SAMPLE_BITS : jac_pkg::CENTER_W;
    localparam int NUM_W = 2 * DW;

    // work item handed from the front end to the back end
    typedef struct packed {
        jac_pkg::kind_t             kind;       // how the result is finished
        logic [SAMPLE_BITS-1:0]     smoothed;   // filter value after this sample
        logic [DW-1:0]              center;     // centre point at classification time
        logic [NUM_W-1:0]           num;        // distance times target span
        logic [DW:0]                den;        // distance from centre to the stop
    } cmd_t;

    jac_pkg::cfg_t  cfg;
    cmd_t           q_in;
    cmd_t           q_out;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    // register bank; the user must write only while the datapath is idle, the block does not enforce it
    jac_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // front end: takes a sample, runs the filter, sorts out the remap case
    jac_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_W        (IN_W),
        .cmd_t       (cmd_t)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .cmd      (q_in),
        .push     (q_push),
        .full     (q_full)
    );

    // decouples the filter from the divider so each side can stall alone
    jac_queue #(
        .entry_t (cmd_t),
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back end: serial division, clamp and the output register
    jac_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_W       (OUT_W),
        .cmd_t       (cmd_t)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop      (q_pop),
        .empty    (q_empty),
        .cmd      (q_out),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // front end works on one sample at a time
    `JAC_ASSERT_NEXT(a_front_busy_after_take, s_tvalid && s_tready, !s_tready, "front end took a second sample while busy")
    // queue never overfills or underflows
    `JAC_ASSERT_IMPL(a_no_push_when_full, q_push, !q_full, "push into a full queue")
    `JAC_ASSERT_IMPL(a_no_pop_when_empty, q_pop, !q_empty, "pop from an empty queue")

endmodule
`default_nettype wire
